@@ rtl/label_color_region_stats_top_macros.svh @@
// Assertion macros used by the checker of the label colour region statistics block.
`ifndef LABEL_COLOR_REGION_STATS_TOP_MACROS_SVH
`define LABEL_COLOR_REGION_STATS_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lcrs_pkg.sv @@
// Package with types, codes and constants of the label colour region statistics block.
`timescale 1ns / 1ps
`default_nettype none

package lcrs_pkg;

    // Default table depth and pixel count width.
    localparam int LCRS_MAX_LABELS = 256;
    localparam int LCRS_COUNT_BITS = 24;

    // Fixed field widths.
    localparam int COLOUR_W  = 24;
    localparam int COORD_W   = 12;
    localparam int GREY_W    = 8;
    localparam int LABEL_W   = 8;
    localparam int SIZE_W    = 24;
    localparam int USED_W    = 9;
    localparam int CMD_W     = 2;
    localparam int S_DATA_W  = 152;
    localparam int M_DATA_W  = 80;

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_LEARN    = 2'd1,
        CMD_CLASSIFY = 2'd2
    } cmd_t;

    // Control part of the token that walks along the cell row.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic hit;
        logic inserted;
    } tok_ctrl_t;

    // Top level sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

endpackage

`default_nettype wire

@@ rtl/lcrs_cell.sv @@
// One table cell: holds a colour and its pixel count and passes the token to the next cell.
`timescale 1ns / 1ps
`default_nettype none

module lcrs_cell
    import lcrs_pkg::*;
#(
    parameter int MAX_LABELS = LCRS_MAX_LABELS,
    parameter int COUNT_BITS = LCRS_COUNT_BITS,
    parameter int IDX        = 0
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic [$clog2(MAX_LABELS+1)-1:0]   used,
    input  wire tok_ctrl_t                         ctrl_in,
    input  wire logic [COLOUR_W-1:0]               colour_in,
    input  wire logic [$clog2(MAX_LABELS)-1:0]     index_in,
    input  wire logic [COUNT_BITS-1:0]             size_in,
    output tok_ctrl_t                              ctrl_out,
    output logic [COLOUR_W-1:0]                    colour_out,
    output logic [$clog2(MAX_LABELS)-1:0]          index_out,
    output logic [COUNT_BITS-1:0]                  size_out
);

    localparam int UW = $clog2(MAX_LABELS + 1);
    localparam int IW = $clog2(MAX_LABELS);

    logic [COLOUR_W-1:0]   colour_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  in_use;
    logic                  open;
    logic                  match;
    logic                  insert;
    logic                  is_classify;

    // Match and insert decisions for the token at this cell's input.
    always_comb
    begin
        in_use      = (used > UW'(IDX));
        is_classify = (ctrl_in.cmd == CMD_CLASSIFY);
        open        = ctrl_in.valid && !ctrl_in.hit;
        match       = open && in_use && (colour_reg == colour_in)
                      && ((ctrl_in.cmd == CMD_LEARN) || is_classify);
        insert      = open && (ctrl_in.cmd == CMD_LEARN) && (used == UW'(IDX));
        if (count_reg == {COUNT_BITS{1'b1}})
        begin
            count_inc = count_reg;
        end
        else
        begin
            count_inc = count_reg + COUNT_BITS'(1);
        end
    end

    // Stored colour and count of this entry.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (insert)
            begin
                colour_reg <= colour_in;
                count_reg  <= '0;
            end
            else if (match && is_classify)
            begin
                count_reg <= count_inc;
            end
        end
    end

    // Token control toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_out <= '0;
        end
        else if (en)
        begin
            ctrl_out.valid    <= ctrl_in.valid;
            ctrl_out.cmd      <= ctrl_in.cmd;
            ctrl_out.hit      <= ctrl_in.hit || match || insert;
            ctrl_out.inserted <= ctrl_in.inserted || insert;
        end
    end

    // Token payload toward the next cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            colour_out <= colour_in;
            if (match || insert)
            begin
                index_out <= IW'(IDX);
            end
            else
            begin
                index_out <= index_in;
            end
            if (match)
            begin
                size_out <= is_classify ? count_inc : count_reg;
            end
            else if (insert)
            begin
                size_out <= '0;
            end
            else
            begin
                size_out <= size_in;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/label_color_region_stats_top.sv @@
// Top level of the label colour region statistics block: a row of table cells and the sequencer.
//
//  channel  | direction | tdata (152 / 80 bits)                        | tuser
//  s_*      | in        | centre, up, down, left, right, row, col, grey | command
//  m_*      | out       | index, found, contour, row, col, grey, size,  | none
//           |           | used, full, zero pad                          |
//
// An accepted word walks the row of MAX_LABELS cells one cell per cycle while the row is
// not frozen; its result is then loaded into the output register, and the next word can be
// accepted in the cycle after that load.
// A low m_tready while a result waits freezes the whole cell row once the word reaches its end.
// Reset empties the table at once by clearing the entry count; no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module label_color_region_stats_top
    import lcrs_pkg::*;
#(
    parameter int MAX_LABELS = LCRS_MAX_LABELS,
    parameter int COUNT_BITS = LCRS_COUNT_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // centre_colour, up_colour, down_colour, left_colour, right_colour, pixel_row,
    // pixel_col, grey_level
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // command
    input  wire logic [CMD_W-1:0]    s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // label_index, found, on_contour, out_row, out_col, out_grey, region_size,
    // labels_used, table_full, 4 zero bits
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int UW = $clog2(MAX_LABELS + 1);
    localparam int IW = $clog2(MAX_LABELS);

    state_t                state_reg;
    state_t                state_next;
    logic [UW-1:0]         used_reg;
    logic [UW-1:0]         used_next;
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic [M_DATA_W-1:0]   out_data_next;
    logic [COORD_W-1:0]    row_reg;
    logic [COORD_W-1:0]    col_reg;
    logic [GREY_W-1:0]     grey_reg;
    logic                  contour_reg;
    logic                  accept;
    logic                  out_load;
    logic                  advance;
    logic                  contour_in;
    logic [31:0]           size_ext;
    logic [SIZE_W-1:0]     size_sat;

    tok_ctrl_t             ctrl   [0:MAX_LABELS];
    logic [COLOUR_W-1:0]   colour [0:MAX_LABELS];
    logic [IW-1:0]         index  [0:MAX_LABELS];
    logic [COUNT_BITS-1:0] size   [0:MAX_LABELS];

    // Handshake and row advance.
    always_comb
    begin
        accept   = s_tvalid && s_tready;
        out_load = ctrl[MAX_LABELS].valid && (!out_valid_reg || m_tready);
        advance  = !ctrl[MAX_LABELS].valid || out_load;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_BUSY: s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Token entering the first cell.
    assign contour_in = (s_tdata[47:24] != s_tdata[71:48])
                        || (s_tdata[95:72] != s_tdata[119:96]);

    always_comb
    begin
        ctrl[0].valid    = accept;
        ctrl[0].cmd      = cmd_t'(s_tuser);
        ctrl[0].hit      = 1'b0;
        ctrl[0].inserted = 1'b0;
        colour[0]        = s_tdata[23:0];
        index[0]         = '0;
        size[0]          = '0;
    end

    // Pass-through fields held while the token is in the row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg     <= s_tdata[131:120];
            col_reg     <= s_tdata[143:132];
            grey_reg    <= s_tdata[151:144];
            contour_reg <= contour_in;
        end
    end

    // Row of table cells.
    for (genvar i = 0; i < MAX_LABELS; i++)
    begin : g_cell
        lcrs_cell #(
            .MAX_LABELS (MAX_LABELS),
            .COUNT_BITS (COUNT_BITS),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (advance),
            .used       (used_reg),
            .ctrl_in    (ctrl[i]),
            .colour_in  (colour[i]),
            .index_in   (index[i]),
            .size_in    (size[i]),
            .ctrl_out   (ctrl[i+1]),
            .colour_out (colour[i+1]),
            .index_out  (index[i+1]),
            .size_out   (size[i+1])
        );
    end

    // Entry count after the item leaving the row.
    always_comb
    begin
        used_next = used_reg;
        if (ctrl[MAX_LABELS].cmd == CMD_CLEAR)
        begin
            used_next = '0;
        end
        else if (ctrl[MAX_LABELS].inserted)
        begin
            used_next = used_reg + UW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (out_load)
        begin
            used_reg <= used_next;
        end
    end

    // Result word assembly, with the count limited to the field width.
    always_comb
    begin
        size_ext = 32'(size[MAX_LABELS]);
        if (size_ext > 32'(SIZE_W'({SIZE_W{1'b1}})))
        begin
            size_sat = {SIZE_W{1'b1}};
        end
        else
        begin
            size_sat = size_ext[SIZE_W-1:0];
        end
        out_data_next        = '0;
        out_data_next[7:0]   = LABEL_W'(index[MAX_LABELS]);
        out_data_next[8]     = ctrl[MAX_LABELS].hit;
        out_data_next[9]     = contour_reg && (ctrl[MAX_LABELS].cmd == CMD_CLASSIFY);
        out_data_next[21:10] = row_reg;
        out_data_next[33:22] = col_reg;
        out_data_next[41:34] = grey_reg;
        out_data_next[65:42] = size_sat;
        out_data_next[74:66] = USED_W'(used_next);
        out_data_next[75]    = (ctrl[MAX_LABELS].cmd == CMD_LEARN) && !ctrl[MAX_LABELS].hit;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/lcrs_checker.sv @@
// Port-level checker for the label colour region statistics block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "label_color_region_stats_top_macros.svh"

module lcrs_checker
    import lcrs_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // Only one word is in the cell row at a time.
    `LCRS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "word accepted while busy")

    // A waiting result is not withdrawn.
    `LCRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A miss carries no label and no count.
    `LCRS_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tdata[8], (m_tdata[7:0] == 8'd0) && (m_tdata[65:42] == 24'd0), "miss with label or count")

    // A full table and a hit never come together.
    `LCRS_ASSERT_NOW(a_full_excl, m_tvalid, !(m_tdata[75] && m_tdata[8]), "table full flagged on a hit")

endmodule

bind label_color_region_stats_top lcrs_checker u_lcrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the label colour region statistics block.
`timescale 1ns / 1ps

module tb_top;
    import lcrs_pkg::*;

    // The only command code that the package enum leaves out; the block ignores it.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int          CLK_PERIOD     = 20;
    localparam int          RESET_CYCLES   = 9;
    localparam int          RANDOM_ITEMS   = 2000;
    localparam int          RX_HOLD_CYCLES = 800;
    localparam int unsigned COUNT_LIMIT    = 32'((64'd1 << LCRS_COUNT_BITS) - 64'd1);
    localparam int unsigned SIZE_LIMIT     = 32'((64'd1 << SIZE_W) - 64'd1);
    localparam logic [COLOUR_W-1:0] WHITE  = {COLOUR_W{1'b1}};

    // One input word, split into its fields.
    typedef struct packed {
        logic [COLOUR_W-1:0] centre;
        logic [COLOUR_W-1:0] up;
        logic [COLOUR_W-1:0] down;
        logic [COLOUR_W-1:0] left;
        logic [COLOUR_W-1:0] right;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [GREY_W-1:0]   grey;
    } pixel_word_t;

    // One output word, split into its fields.
    typedef struct packed {
        logic [LABEL_W-1:0] index;
        logic               found;
        logic               contour;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [GREY_W-1:0]  grey;
        logic [SIZE_W-1:0]  size;
        logic [USED_W-1:0]  used;
        logic               full;
    } region_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted table contents and the results still owed by the block.
    logic [COLOUR_W-1:0] known_colours [LCRS_MAX_LABELS];
    int unsigned         region_counts [LCRS_MAX_LABELS];
    int unsigned         colours_stored;
    region_result_t      pending_results [$];

    int error_count;
    int burst_left;
    int hold_requests;
    int holds_served;

    label_color_region_stats_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard limit on the run time, far above the slowest correct run.
    initial
    begin
        #(100_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Lowest table index holding the colour, or -1 when it is not stored.
    function automatic int find_colour(logic [COLOUR_W-1:0] colour);
        for (int i = 0; i < int'(colours_stored); i++)
        begin
            if (known_colours[i] == colour)
                return i;
        end
        return -1;
    endfunction

    // Updates the predicted table for one word and returns the result it must give.
    function automatic region_result_t predict_region_result(logic [CMD_W-1:0] cmd,
                                                             pixel_word_t px);
        region_result_t r;
        int             hit;
        int unsigned    size;
        r      = '0;
        size   = 0;
        r.row  = px.row;
        r.col  = px.col;
        r.grey = px.grey;
        if (cmd == CMD_CLEAR)
        begin
            colours_stored = 0;
        end
        else if (cmd == CMD_LEARN)
        begin
            hit = find_colour(px.centre);
            if (hit >= 0)
            begin
                r.index = hit[LABEL_W-1:0];
                r.found = 1'b1;
                size    = region_counts[hit];
            end
            else if (colours_stored < LCRS_MAX_LABELS)
            begin
                r.index                       = colours_stored[LABEL_W-1:0];
                known_colours[colours_stored] = px.centre;
                region_counts[colours_stored] = 0;
                colours_stored++;
                r.found = 1'b1;
            end
            else
            begin
                r.full = 1'b1;
            end
        end
        else if (cmd == CMD_CLASSIFY)
        begin
            // Contour when either pair of opposite neighbours differs.
            r.contour = (px.up != px.down) || (px.left != px.right);
            hit = find_colour(px.centre);
            if (hit >= 0)
            begin
                r.index = hit[LABEL_W-1:0];
                r.found = 1'b1;
                if (region_counts[hit] < COUNT_LIMIT)
                    region_counts[hit]++;
                size = region_counts[hit];
            end
        end
        if (size > SIZE_LIMIT)
            size = SIZE_LIMIT;
        r.size = size[SIZE_W-1:0];
        r.used = colours_stored[USED_W-1:0];
        return r;
    endfunction

    function automatic logic [COLOUR_W-1:0] rand_colour();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WHITE;
            default: return COLOUR_W'($urandom);
        endcase
    endfunction

    function automatic pixel_word_t make_pixel(logic [COLOUR_W-1:0] centre,
                                               logic [COLOUR_W-1:0] up,
                                               logic [COLOUR_W-1:0] down,
                                               logic [COLOUR_W-1:0] left,
                                               logic [COLOUR_W-1:0] right);
        pixel_word_t px;
        px.centre = centre;
        px.up     = up;
        px.down   = down;
        px.left   = left;
        px.right  = right;
        px.row    = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        px.col    = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        px.grey   = GREY_W'($urandom_range(0, (1 << GREY_W) - 1));
        return px;
    endfunction

    // Sends one word, pausing between bursts, and records its expected result on acceptance.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input pixel_word_t px);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            // Mostly short gaps; now and then one long enough to land anywhere in a pass.
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 320) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {px.grey, px.col, px.row, px.right, px.left, px.down, px.up, px.centre};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results = {pending_results, predict_region_result(cmd, px)};
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic wait_for_drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result checker: compares every accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        region_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word %h arrived with no expectation waiting", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("label_index", want.index,   m_tdata[7:0]);
                check_field("found",       want.found,   m_tdata[8]);
                check_field("on_contour",  want.contour, m_tdata[9]);
                check_field("out_row",     want.row,     m_tdata[21:10]);
                check_field("out_col",     want.col,     m_tdata[33:22]);
                check_field("out_grey",    want.grey,    m_tdata[41:34]);
                check_field("region_size", want.size,    m_tdata[65:42]);
                check_field("labels_used", want.used,    m_tdata[74:66]);
                check_field("table_full",  want.full,    m_tdata[75]);
                check_field("pad",         0,            m_tdata[79:76]);
            end
        end
    end

    // Receiver: changes its stall pattern from one random segment to the next, and holds off
    // for a long stretch whenever a test asks for it.
    initial
    begin
        int mode;
        int seg_left;
        int period;
        int low_len;
        int phase;
        m_tready <= 1'b0;
        seg_left = 0;
        mode     = 0;
        period   = 1;
        low_len  = 0;
        phase    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests > holds_served)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(200, 2000);
                mode     = $urandom_range(0, 2);
                period   = $urandom_range(2, 9);
                low_len  = $urandom_range(1, period - 1);
                phase    = 0;
            end
            seg_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    m_tready <= (phase >= low_len);
                    phase = (phase + 1) % period;
                end
            endcase
        end
    end

    // Empty table: unknown colours, contour flags and the ignored command.
    task automatic test_empty_table();
        send_word(CMD_CLEAR, make_pixel('0, '0, '0, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel('0, '0, WHITE, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(WHITE, '0, '0, WHITE, '0));
        send_word(CMD_UNUSED, make_pixel(WHITE, WHITE, WHITE, WHITE, WHITE));
    endtask

    // Learn and classify with extreme colours, duplicates and every contour case.
    task automatic test_learn_classify();
        pixel_word_t px;
        send_word(CMD_LEARN, make_pixel('0, '0, '0, '0, '0));
        send_word(CMD_LEARN, make_pixel(WHITE, WHITE, '0, WHITE, '0));
        send_word(CMD_LEARN, make_pixel('0, WHITE, WHITE, WHITE, WHITE));
        send_word(CMD_CLASSIFY, make_pixel('0, 24'h123456, 24'h123456, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(WHITE, '0, '0, 24'h000001, '0));
        send_word(CMD_CLASSIFY, make_pixel(WHITE, 24'h800000, '0, WHITE, WHITE));
        send_word(CMD_CLASSIFY, make_pixel(WHITE, WHITE, '0, '0, WHITE));
        send_word(CMD_CLASSIFY, make_pixel(24'h5A5A5A, '0, '0, '0, '0));
        send_word(CMD_LEARN, make_pixel(24'hA5A5A5, '0, '0, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(24'hA5A5A5, '0, '0, '0, '0));
        // Coordinate and grey extremes.
        px      = make_pixel('0, '0, '0, '0, '0);
        px.row  = '0;
        px.col  = '0;
        px.grey = '0;
        send_word(CMD_CLASSIFY, px);
        px.row  = '1;
        px.col  = '1;
        px.grey = '1;
        send_word(CMD_CLASSIFY, px);
        send_word(CMD_UNUSED, px);
        send_word(CMD_LEARN, px);
        // A cleared table forgets colours that were known.
        send_word(CMD_CLEAR, px);
        send_word(CMD_CLASSIFY, make_pixel(WHITE, '0, '0, '0, '0));
    endtask

    // Fill every entry, then try to insert one more colour.
    task automatic test_table_full();
        logic [COLOUR_W-1:0] last_colour;
        send_word(CMD_CLEAR, make_pixel('0, '0, '0, '0, '0));
        for (int i = 0; i < LCRS_MAX_LABELS; i++)
        begin
            last_colour = {i[7:0], 8'h5A ^ i[7:0], ~i[7:0]};
            send_word(CMD_LEARN, make_pixel(last_colour, '0, '0, '0, '0));
        end
        send_word(CMD_LEARN, make_pixel(24'hFEDCBA, '0, '0, '0, '0));
        send_word(CMD_LEARN, make_pixel(last_colour, '0, '0, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(last_colour, WHITE, '0, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(24'hFEDCBA, '0, '0, '0, '0));
        send_word(CMD_UNUSED, make_pixel(last_colour, '0, '0, '0, '0));
        send_word(CMD_CLEAR, make_pixel('0, '0, '0, '0, '0));
    endtask

    // Receiver holds off while words keep coming, so the block stalls its input.
    task automatic test_backpressure();
        hold_requests++;
        send_word(CMD_LEARN, make_pixel(24'h00FF00, '0, '0, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(24'h00FF00, '0, WHITE, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(24'h00FF00, '0, '0, '0, '0));
        send_word(CMD_CLASSIFY, make_pixel(24'h0000FF, '0, '0, '0, WHITE));
        wait_for_drain();
        send_word(CMD_CLASSIFY, make_pixel(24'h00FF00, '0, '0, '0, '0));
    endtask

    // Random frames: learn a palette, then classify pixels drawn from it, with noise and stray commands.
    task automatic test_random_frames();
        logic [COLOUR_W-1:0] palette [$];
        logic [COLOUR_W-1:0] up;
        logic [COLOUR_W-1:0] down;
        logic [COLOUR_W-1:0] left;
        logic [COLOUR_W-1:0] right;
        logic [COLOUR_W-1:0] centre;
        int                  items;
        int                  n_colours;
        int                  sel;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            palette.delete();
            n_colours = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 12);
            repeat (n_colours) palette = {palette, rand_colour()};
            if ($urandom_range(0, 2) == 0)
            begin
                send_word(CMD_CLEAR, make_pixel(rand_colour(), '0, '0, '0, '0));
                items++;
            end
            foreach (palette[i])
            begin
                send_word(CMD_LEARN, make_pixel(palette[i], rand_colour(), rand_colour(),
                                                rand_colour(), rand_colour()));
                items++;
            end
            repeat ($urandom_range(10, 60))
            begin
                sel = $urandom_range(0, 99);
                if (sel < 3)
                begin
                    send_word(CMD_UNUSED, make_pixel(rand_colour(), rand_colour(),
                                                     rand_colour(), rand_colour(),
                                                     rand_colour()));
                end
                else
                begin
                    up     = palette[$urandom_range(0, palette.size() - 1)];
                    down   = $urandom_range(0, 1) ? up
                                                  : palette[$urandom_range(0, palette.size() - 1)];
                    left   = palette[$urandom_range(0, palette.size() - 1)];
                    right  = $urandom_range(0, 1) ? left
                                                  : palette[$urandom_range(0, palette.size() - 1)];
                    centre = (sel < 15) ? rand_colour()
                                        : palette[$urandom_range(0, palette.size() - 1)];
                    if (sel < 5)
                        send_word(CMD_LEARN, make_pixel(rand_colour(), up, down, left, right));
                    else if (sel < 6)
                        send_word(CMD_CLEAR, make_pixel(centre, up, down, left, right));
                    else
                        send_word(CMD_CLASSIFY, make_pixel(centre, up, down, left, right));
                    items++;
                end
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        error_count   = 0;
        burst_left    = 0;
        hold_requests = 0;
        holds_served  = 0;
        colours_stored = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_learn_classify();
        test_table_full();
        test_backpressure();
        test_random_frames();

        wait_for_drain();
        repeat (LCRS_MAX_LABELS + 8) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
